// File: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the dedispersion block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, masked while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: hw/rtl/idss_pkg.sv
// Package for the dedispersion delay-and-sum block: sizes, codes, shared types
// and helper functions. No dependencies.
package idss_pkg;

    // Sizing
    localparam int MAX_CHANNELS = 1024;
    localparam int CH_AW        = $clog2(MAX_CHANNELS);
    localparam int RING_AW      = 12;
    localparam int RING_DEPTH   = 2 ** RING_AW;

    // Field widths
    localparam int CHANNEL_W = 10;
    localparam int POL_W     = 8;
    localparam int DELAY_W   = 12;
    localparam int SUM_W     = 19;
    localparam int ACC_W     = 20;
    localparam int CFG_W     = 11;
    localparam int CHAN_RESET = 1024;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // Lanes and output queue
    localparam int NUM_LANES     = 4;
    localparam int LANE_TOTAL    = 0;
    localparam int LANE_DIFF     = 1;
    localparam int LANE_CROSS_RE = 2;
    localparam int LANE_CROSS_IM = 3;
    localparam int OUT_AW        = 2;
    localparam int OUT_DEPTH     = 2 ** OUT_AW;
    localparam int OUT_CW        = $clog2(OUT_DEPTH + 1);

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_DELAY = 1'b1
    } t_op;

    typedef enum logic [PADDR_W-3:0] {
        REG_CHANNELS_IN_USE = '0
    } t_reg;

    typedef logic [ACC_W-1:0]   t_acc;
    typedef logic [RING_AW-1:0] t_slot;

    typedef struct packed {
        logic                  valid;
        logic                  last;
        t_slot                 acc_slot;
        t_slot                 emit_slot;
        logic                  init_we;
        t_slot                 init_slot;
        t_acc [NUM_LANES-1:0]  addend;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_acc value;
    } t_lane_out;

    typedef struct packed {
        logic        [SUM_W-1:0] sum_total;
        logic signed [SUM_W-1:0] sum_difference;
        logic        [SUM_W-1:0] sum_cross_real;
        logic        [SUM_W-1:0] sum_cross_imag;
    } t_result;

    // Last channel index for a channel count, clamped to 1..MAX_CHANNELS.
    function automatic logic [CFG_W-1:0] last_of(logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] r;
        if (n == '0) begin
            r = '0;
        end else if (int'(n) > MAX_CHANNELS) begin
            r = CFG_W'(MAX_CHANNELS - 1);
        end else begin
            r = n - CFG_W'(1);
        end
        return r;
    endfunction

    // Ring slot of time slot plus delay, wrapping at the ring depth.
    function automatic t_slot slot_of(t_slot t, logic [DELAY_W-1:0] d);
        logic [RING_AW+DELAY_W-1:0] s;
        s = (RING_AW + DELAY_W)'(t) + (RING_AW + DELAY_W)'(d);
        return s[RING_AW-1:0];
    endfunction

endpackage

// File: hw/rtl/idss_in_if.sv
// Input channel of the dedispersion block: valid/ready plus one filterbank
// item or delay entry. Uses idss_pkg.
interface idss_in_if;
    logic                            valid;
    logic                            ready;
    logic                            operation;
    logic [idss_pkg::CHANNEL_W-1:0]  channel;
    logic [idss_pkg::POL_W-1:0]      pol_a;
    logic [idss_pkg::POL_W-1:0]      pol_b;
    logic [idss_pkg::POL_W-1:0]      pol_c;
    logic [idss_pkg::POL_W-1:0]      pol_d;
    logic [idss_pkg::DELAY_W-1:0]    delay_samples;

    modport source (
        output valid, operation, channel, pol_a, pol_b, pol_c, pol_d, delay_samples,
        input  ready
    );
    modport sink (
        input  valid, operation, channel, pol_a, pol_b, pol_c, pol_d, delay_samples,
        output ready
    );
endinterface

// File: hw/rtl/idss_out_if.sv
// Output channel of the dedispersion block: valid/ready plus the four
// channel-summed values of one time sample. Uses idss_pkg.
interface idss_out_if;
    logic                               valid;
    logic                               ready;
    logic        [idss_pkg::SUM_W-1:0]  sum_total;
    logic signed [idss_pkg::SUM_W-1:0]  sum_difference;
    logic        [idss_pkg::SUM_W-1:0]  sum_cross_real;
    logic        [idss_pkg::SUM_W-1:0]  sum_cross_imag;

    modport source (
        output valid, sum_total, sum_difference, sum_cross_real, sum_cross_imag,
        input  ready
    );
    modport sink (
        input  valid, sum_total, sum_difference, sum_cross_real, sum_cross_imag,
        output ready
    );
endinterface

// File: hw/rtl/idss_front.sv
// Front end: register port, delay table, time slot, ring clear sweep and the
// per-lane command for each data transaction. Uses idss_pkg and idss_in_if.
module idss_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [idss_pkg::PADDR_W-1:0]   paddr,
    input  logic [idss_pkg::PDATA_W-1:0]   pwdata,
    output logic [idss_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    idss_in_if.sink                        i_in,
    input  logic                           i_room,
    output idss_pkg::t_cmd                 o_cmd
);

    logic [idss_pkg::CFG_W-1:0]     r_chan_cnt;
    logic [idss_pkg::CFG_W-1:0]     r_last_ch;
    logic                           r_init_busy;
    idss_pkg::t_slot                r_init_slot;
    logic                           r_bubble;
    idss_pkg::t_slot                r_time;
    logic                           r_a_valid;
    logic [idss_pkg::CHANNEL_W-1:0] r_a_ch;
    logic [idss_pkg::POL_W-1:0]     r_a_pol_a;
    logic [idss_pkg::POL_W-1:0]     r_a_pol_b;
    logic [idss_pkg::POL_W-1:0]     r_a_pol_c;
    logic [idss_pkg::POL_W-1:0]     r_a_pol_d;
    logic [idss_pkg::DELAY_W-1:0]   r_dly;
    logic [idss_pkg::DELAY_W-1:0]   r_dly_mem [idss_pkg::MAX_CHANNELS];

    logic                           cfg_wr;
    logic                           accept;
    logic                           in_range;
    logic                           is_data;
    logic                           in_last;
    logic [idss_pkg::CH_AW-1:0]     dly_idx;
    logic                           a_last;

    assign pready = 1'b1;
    assign prdata = idss_pkg::PDATA_W'(r_chan_cnt);
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[idss_pkg::PADDR_W-1:2] == idss_pkg::REG_CHANNELS_IN_USE);

    assign accept   = i_in.valid && i_in.ready;
    assign in_range = int'(i_in.channel) < idss_pkg::MAX_CHANNELS;
    assign is_data  = i_in.operation == idss_pkg::OP_DATA;
    assign in_last  = idss_pkg::CFG_W'(i_in.channel) == r_last_ch;
    assign dly_idx  = idss_pkg::CH_AW'(i_in.channel);

    // Hold off input after a sample closes so the ring write port can clear it.
    assign i_in.ready = !r_init_busy && !r_bubble && i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_cnt  <= idss_pkg::CFG_W'(idss_pkg::CHAN_RESET);
            r_last_ch   <= idss_pkg::last_of(idss_pkg::CFG_W'(idss_pkg::CHAN_RESET));
            r_init_busy <= 1'b1;
            r_init_slot <= '0;
            r_bubble    <= 1'b0;
            r_time      <= '0;
            r_a_valid   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_chan_cnt <= pwdata[idss_pkg::CFG_W-1:0];
                r_last_ch  <= idss_pkg::last_of(pwdata[idss_pkg::CFG_W-1:0]);
            end
            if (r_init_busy) begin
                r_init_slot <= r_init_slot + idss_pkg::RING_AW'(1);
                if (r_init_slot == idss_pkg::RING_AW'(idss_pkg::RING_DEPTH - 1)) begin
                    r_init_busy <= 1'b0;
                end
            end
            r_bubble  <= accept && in_range && is_data && in_last;
            r_a_valid <= accept && in_range && is_data;
            if (r_a_valid && a_last) begin
                r_time <= r_time + idss_pkg::RING_AW'(1);
            end
        end
    end

    // Delay table and stage A payload
    always_ff @(posedge i_clk) begin
        if (accept && in_range && !is_data) begin
            r_dly_mem[dly_idx] <= i_in.delay_samples;
        end
        if (accept) begin
            r_dly     <= r_dly_mem[dly_idx];
            r_a_ch    <= i_in.channel;
            r_a_pol_a <= i_in.pol_a;
            r_a_pol_b <= i_in.pol_b;
            r_a_pol_c <= i_in.pol_c;
            r_a_pol_d <= i_in.pol_d;
        end
    end

    assign a_last = idss_pkg::CFG_W'(r_a_ch) == r_last_ch;

    always_comb begin
        o_cmd           = '0;
        o_cmd.valid     = r_a_valid;
        o_cmd.last      = a_last;
        o_cmd.acc_slot  = idss_pkg::slot_of(r_time, r_dly);
        o_cmd.emit_slot = r_time;
        o_cmd.init_we   = r_init_busy;
        o_cmd.init_slot = r_init_slot;
        o_cmd.addend[idss_pkg::LANE_TOTAL] =
            idss_pkg::ACC_W'(r_a_pol_a) + idss_pkg::ACC_W'(r_a_pol_b);
        // Wraps to the two's complement of a - b
        o_cmd.addend[idss_pkg::LANE_DIFF] =
            idss_pkg::ACC_W'(r_a_pol_a) - idss_pkg::ACC_W'(r_a_pol_b);
        o_cmd.addend[idss_pkg::LANE_CROSS_RE] = idss_pkg::ACC_W'({r_a_pol_c, 1'b0});
        o_cmd.addend[idss_pkg::LANE_CROSS_IM] = idss_pkg::ACC_W'({r_a_pol_d, 1'b0});
    end

endmodule

// File: hw/rtl/idss_lane.sv
// One accumulation lane: ring of per-time accumulators with read-modify-write,
// write forwarding, emission read and slot clear. Uses idss_pkg.
module idss_lane (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  idss_pkg::t_cmd        i_cmd,
    input  idss_pkg::t_acc        i_addend,
    output idss_pkg::t_lane_out   o_out
);

    idss_pkg::t_acc   r_ring [idss_pkg::RING_DEPTH];
    idss_pkg::t_acc   r_rd_acc;
    idss_pkg::t_acc   r_rd_emit;
    logic             r_b_valid;
    logic             r_b_last;
    idss_pkg::t_slot  r_b_acc_slot;
    idss_pkg::t_slot  r_b_emit_slot;
    idss_pkg::t_acc   r_b_add;
    logic             r_clr_pend;
    idss_pkg::t_slot  r_clr_slot;
    logic             r_fw_valid;
    idss_pkg::t_slot  r_fw_slot;
    idss_pkg::t_acc   r_fw_data;

    idss_pkg::t_acc   fwd_acc;
    idss_pkg::t_acc   fwd_emit;
    idss_pkg::t_acc   acc_sum;
    logic             same_slot;
    logic             close;
    logic             wr_en;
    idss_pkg::t_slot  wr_slot;
    idss_pkg::t_acc   wr_data;

    // The write at the read edge is not yet in the ring: take it from the bypass.
    assign fwd_acc  = (r_fw_valid && (r_fw_slot == r_b_acc_slot)) ? r_fw_data : r_rd_acc;
    assign fwd_emit = (r_fw_valid && (r_fw_slot == r_b_emit_slot)) ? r_fw_data : r_rd_emit;
    assign acc_sum   = fwd_acc + r_b_add;
    assign same_slot = r_b_acc_slot == r_b_emit_slot;
    assign close     = r_b_valid && r_b_last;

    always_comb begin
        wr_en   = 1'b0;
        wr_slot = r_b_acc_slot;
        wr_data = acc_sum;
        priority if (i_cmd.init_we) begin
            wr_en   = 1'b1;
            wr_slot = i_cmd.init_slot;
            wr_data = '0;
        end else if (r_clr_pend) begin
            wr_en   = 1'b1;
            wr_slot = r_clr_slot;
            wr_data = '0;
        end else if (r_b_valid) begin
            wr_en   = 1'b1;
            wr_slot = r_b_acc_slot;
            // Closing item lands on the slot it empties: store the cleared value
            wr_data = (close && same_slot) ? '0 : acc_sum;
        end
    end

    assign o_out.valid = close;
    assign o_out.value = same_slot ? acc_sum : fwd_emit;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ring[wr_slot] <= wr_data;
        end
        r_rd_acc      <= r_ring[i_cmd.acc_slot];
        r_rd_emit     <= r_ring[i_cmd.emit_slot];
        r_b_acc_slot  <= i_cmd.acc_slot;
        r_b_emit_slot <= i_cmd.emit_slot;
        r_b_add       <= i_addend;
        r_clr_slot    <= r_b_emit_slot;
        r_fw_slot     <= wr_slot;
        r_fw_data     <= wr_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_b_last   <= 1'b0;
            r_clr_pend <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_b_valid  <= i_cmd.valid;
            r_b_last   <= i_cmd.last;
            r_clr_pend <= close && !same_slot;
            r_fw_valid <= wr_en;
        end
    end

endmodule

// File: hw/rtl/idss_merge.sv
// Merge stage: joins the lane sums into one result, queues results for the
// output channel and reports room for more. Uses idss_pkg and idss_out_if.
module idss_merge (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  idss_pkg::t_cmd                                i_cmd,
    input  idss_pkg::t_lane_out [idss_pkg::NUM_LANES-1:0] i_lanes,
    idss_out_if.source                                    o_out,
    output logic                                          o_room
);

    idss_pkg::t_result            r_fifo [idss_pkg::OUT_DEPTH];
    logic [idss_pkg::OUT_AW-1:0]  r_wr_ptr;
    logic [idss_pkg::OUT_AW-1:0]  r_rd_ptr;
    logic [idss_pkg::OUT_CW-1:0]  r_count;

    logic                         push;
    logic                         pop;
    idss_pkg::t_result            result;
    idss_pkg::t_result            head;
    logic [idss_pkg::OUT_CW:0]    pending;

    assign push = i_lanes[idss_pkg::LANE_TOTAL].valid;
    assign pop  = o_out.valid && o_out.ready;

    always_comb begin
        result.sum_total      = i_lanes[idss_pkg::LANE_TOTAL].value[idss_pkg::SUM_W-1:0];
        result.sum_difference = i_lanes[idss_pkg::LANE_DIFF].value[idss_pkg::SUM_W-1:0];
        result.sum_cross_real = i_lanes[idss_pkg::LANE_CROSS_RE].value[idss_pkg::SUM_W-1:0];
        result.sum_cross_imag = i_lanes[idss_pkg::LANE_CROSS_IM].value[idss_pkg::SUM_W-1:0];
    end

    // Reserve a place for every result still in the lanes plus one more transaction.
    assign pending = (idss_pkg::OUT_CW + 1)'(r_count)
                   + (idss_pkg::OUT_CW + 1)'(i_cmd.valid && i_cmd.last)
                   + (idss_pkg::OUT_CW + 1)'(push);
    assign o_room  = pending < (idss_pkg::OUT_CW + 1)'(idss_pkg::OUT_DEPTH);

    assign head                 = r_fifo[r_rd_ptr];
    assign o_out.valid          = r_count != '0;
    assign o_out.sum_total      = head.sum_total;
    assign o_out.sum_difference = head.sum_difference;
    assign o_out.sum_cross_real = head.sum_cross_real;
    assign o_out.sum_cross_imag = head.sum_cross_imag;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + idss_pkg::OUT_AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + idss_pkg::OUT_AW'(1);
            end
            unique case ({push, pop})
                2'b10:   r_count <= r_count + idss_pkg::OUT_CW'(1);
                2'b01:   r_count <= r_count - idss_pkg::OUT_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// File: hw/rtl/incoherent_dedispersion_stokes_sum_top.sv
// Channel    Direction  Handshake          Payload
// i_in_ch    in         valid/ready        operation, channel, pol_a..pol_d, delay_samples
// o_out_ch   out        valid/ready        sum_total, sum_difference, sum_cross_real/imag
// APB        in/out     psel/penable       channels_in_use at byte address 0
//
// One transaction per cycle while input ready is high; a data transaction closing a sample
// is followed by a bubble, since the ring memories' single write port clears that slot.
// A closing transaction's result passes stage A, stage B and the result queue to o_out_ch.
// After reset the rings are swept to zero, slot by slot, with input ready low.
// A four-entry result queue lets input run on while o_out_ch is stalled.
// Top level of the incoherent delay-and-sum block; uses idss_pkg, the channel
// interfaces, idss_front, idss_lane and idss_merge.
module incoherent_dedispersion_stokes_sum_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [idss_pkg::PADDR_W-1:0]   paddr,
    input  logic [idss_pkg::PDATA_W-1:0]   pwdata,
    output logic [idss_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    idss_in_if.sink                        i_in_ch,
    idss_out_if.source                     o_out_ch
);

    idss_pkg::t_cmd                                cmd;
    idss_pkg::t_lane_out [idss_pkg::NUM_LANES-1:0] lane_out;
    logic                                          room;

    idss_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (i_in_ch),
        .i_room  (room),
        .o_cmd   (cmd)
    );

    for (genvar g = 0; g < idss_pkg::NUM_LANES; g++) begin : g_lane
        idss_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cmd    (cmd),
            .i_addend (cmd.addend[g]),
            .o_out    (lane_out[g])
        );
    end

    idss_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_lanes (lane_out),
        .o_out   (o_out_ch),
        .o_room  (room)
    );

endmodule

// File: hw/rtl/idss_checker.sv
// Port-level checker for the dedispersion top level, bound to it below.
// Uses assert_macros.svh and idss_pkg.
`include "assert_macros.svh"

module idss_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_in_operation,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic        [idss_pkg::SUM_W-1:0]  i_out_sum_total,
    input logic signed [idss_pkg::SUM_W-1:0]  i_out_sum_difference,
    input logic        [idss_pkg::SUM_W-1:0]  i_out_sum_cross_real,
    input logic        [idss_pkg::SUM_W-1:0]  i_out_sum_cross_imag
);

    // The ring sweep keeps input closed right after reset
    `ASSERT_NEXT_NORST(a_ready_low_after_reset, i_clk, !i_rst_n, !i_in_ready)

    `ASSERT_NEXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    `ASSERT_NEXT(a_out_payload_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_sum_total) && $stable(i_out_sum_difference) && $stable(i_out_sum_cross_real) && $stable(i_out_sum_cross_imag))

    // A result from an empty queue comes from an accepted data transaction through stages A and B
    `ASSERT_IMP(a_result_from_data, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready && (i_in_operation == idss_pkg::OP_DATA), 3))

endmodule

bind incoherent_dedispersion_stokes_sum_top idss_checker u_idss_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .i_in_valid           (i_in_ch.valid),
    .i_in_ready           (i_in_ch.ready),
    .i_in_operation       (i_in_ch.operation),
    .i_out_valid          (o_out_ch.valid),
    .i_out_ready          (o_out_ch.ready),
    .i_out_sum_total      (o_out_ch.sum_total),
    .i_out_sum_difference (o_out_ch.sum_difference),
    .i_out_sum_cross_real (o_out_ch.sum_cross_real),
    .i_out_sum_cross_imag (o_out_ch.sum_cross_imag)
);

// File: test/incoherent_dedispersion_stokes_sum_top_tb.sv
// Self-checking testbench for the incoherent delay-and-sum block: directed table, then random
// phases over several channel counts; results checked against typed or predicted sums.
// Depends on idss_pkg, idss_in_if, idss_out_if and incoherent_dedispersion_stokes_sum_top.
module incoherent_dedispersion_stokes_sum_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idss_pkg::*;

    typedef struct packed {
        t_op                  op;
        logic [CHANNEL_W-1:0] ch;
        logic [POL_W-1:0]     a;
        logic [POL_W-1:0]     b;
        logic [POL_W-1:0]     c;
        logic [POL_W-1:0]     d;
        logic [DELAY_W-1:0]   dl;
        logic                 typed;
        t_result              exp;
    } fb_item_t;

    typedef struct packed {
        logic             is_cfg;
        logic [CFG_W-1:0] cfg_val;
        fb_item_t         item;
    } dir_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    idss_in_if  in_ch ();
    idss_out_if out_ch ();

    incoherent_dedispersion_stokes_sum_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: delay table, accumulator ring, current time slot, channel count.
    logic [DELAY_W-1:0] delay_tab [MAX_CHANNELS];
    logic [ACC_W-1:0]   acc_tot   [RING_DEPTH];
    logic [SUM_W-1:0]   acc_dif   [RING_DEPTH];
    logic [ACC_W-1:0]   acc_xr    [RING_DEPTH];
    logic [ACC_W-1:0]   acc_xi    [RING_DEPTH];
    t_slot              slot_now;
    logic [CFG_W-1:0]   chan_cfg;

    // Generation-side view of which delay entries have been loaded.
    bit delay_loaded [MAX_CHANNELS];

    fb_item_t send_q [$];
    t_result  sum_expect_q [$];
    fb_item_t cur_item;
    t_result  pred;
    t_result  want;
    bit       has;
    int       n_queued = 0;
    int       n_accepted = 0;
    int       n_err = 0;
    int       src_pct = 20;
    int       snk_pct = 20;
    int       gap = 0;
    int       stall = 0;

    // Load a delay or accumulate data; return 1 with the sums of a sample it closes.
    function automatic bit dedisperse_step(input fb_item_t it, output t_result r);
        t_slot tgt;
        int    last;
        r = '0;
        if (it.op == OP_DELAY) begin
            delay_tab[it.ch] = it.dl;
            return 1'b0;
        end
        tgt = t_slot'(slot_now + delay_tab[it.ch]);
        acc_tot[tgt] = acc_tot[tgt] + ACC_W'(it.a) + ACC_W'(it.b);
        acc_dif[tgt] = acc_dif[tgt] + SUM_W'(it.a) - SUM_W'(it.b);
        acc_xr[tgt]  = acc_xr[tgt] + (ACC_W'(it.c) << 1);
        acc_xi[tgt]  = acc_xi[tgt] + (ACC_W'(it.d) << 1);
        if (chan_cfg == '0) begin
            last = 0;
        end else if (int'(chan_cfg) > MAX_CHANNELS) begin
            last = MAX_CHANNELS - 1;
        end else begin
            last = int'(chan_cfg) - 1;
        end
        if (int'(it.ch) != last) return 1'b0;
        r.sum_total      = acc_tot[slot_now][SUM_W-1:0];
        r.sum_difference = acc_dif[slot_now];
        r.sum_cross_real = acc_xr[slot_now][SUM_W-1:0];
        r.sum_cross_imag = acc_xi[slot_now][SUM_W-1:0];
        acc_tot[slot_now] = '0;
        acc_dif[slot_now] = '0;
        acc_xr[slot_now]  = '0;
        acc_xi[slot_now]  = '0;
        slot_now = slot_now + 1'b1;
        return 1'b1;
    endfunction

    // Input side: hold until accepted, idle in random bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            gap = 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                has = dedisperse_step(cur_item, pred);
                if (cur_item.typed) begin
                    sum_expect_q.push_back(cur_item.exp);
                end else if (has) begin
                    sum_expect_q.push_back(pred);
                end
                n_accepted++;
            end
            if (in_ch.valid && !in_ch.ready) begin
                // hold the pending transaction
            end else if (gap > 0) begin
                gap--;
                in_ch.valid <= 1'b0;
            end else if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
                gap = $urandom_range(1, 19) - 1;
                in_ch.valid <= 1'b0;
            end else if (send_q.size() != 0) begin
                cur_item = send_q.pop_front();
                in_ch.operation     <= cur_item.op;
                in_ch.channel       <= cur_item.ch;
                in_ch.pol_a         <= cur_item.a;
                in_ch.pol_b         <= cur_item.b;
                in_ch.pol_c         <= cur_item.c;
                in_ch.pol_d         <= cur_item.d;
                in_ch.delay_samples <= cur_item.dl;
                in_ch.valid         <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    task automatic mismatch(input string field, input int expd, input int act);
        n_err++;
        $error("%s: expected %0d, actual %0d", field, expd, act);
    endtask

    // Output side: compare each result against the oldest expectation, stall in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            stall = 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (sum_expect_q.size() == 0) begin
                    n_err++;
                    $error("result transaction with no expectation waiting");
                end else begin
                    want = sum_expect_q.pop_front();
                    if (out_ch.sum_total !== want.sum_total)
                        mismatch("sum_total", int'(want.sum_total), int'(out_ch.sum_total));
                    if (out_ch.sum_difference !== want.sum_difference)
                        mismatch("sum_difference", int'(want.sum_difference),
                                 int'(out_ch.sum_difference));
                    if (out_ch.sum_cross_real !== want.sum_cross_real)
                        mismatch("sum_cross_real", int'(want.sum_cross_real),
                                 int'(out_ch.sum_cross_real));
                    if (out_ch.sum_cross_imag !== want.sum_cross_imag)
                        mismatch("sum_cross_imag", int'(want.sum_cross_imag),
                                 int'(out_ch.sum_cross_imag));
                end
            end
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (snk_pct != 0 && $urandom_range(0, 99) < snk_pct) begin
                stall = $urandom_range(1, 19) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input t_reg idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        chan_cfg = val;
    endtask

    // Wait until every transaction is accepted and every result has come back.
    task automatic wait_drained();
        do @(negedge i_clk); while (n_accepted != n_queued || sum_expect_q.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [POL_W-1:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return POL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int pick_delay();
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, 4095);
        return $urandom_range(0, 15);
    endfunction

    task automatic queue_item(input fb_item_t it);
        if (it.op == OP_DELAY) delay_loaded[it.ch] = 1'b1;
        send_q.push_back(it);
        n_queued++;
    endtask

    task automatic queue_delay(input int ch, input int dl);
        fb_item_t it;
        it = '0;
        it.op = OP_DELAY;
        it.ch = CHANNEL_W'(ch);
        it.a  = rand_byte();
        it.b  = rand_byte();
        it.c  = rand_byte();
        it.d  = rand_byte();
        it.dl = DELAY_W'(dl);
        queue_item(it);
    endtask

    // Data for a channel; load a delay first if the entry was never written.
    task automatic queue_data(input int ch);
        fb_item_t it;
        if (!delay_loaded[ch]) queue_delay(ch, pick_delay());
        it = '0;
        it.op = OP_DATA;
        it.ch = CHANNEL_W'(ch);
        it.a  = rand_byte();
        it.b  = rand_byte();
        it.c  = rand_byte();
        it.d  = rand_byte();
        it.dl = DELAY_W'($urandom_range(0, 4095));
        queue_item(it);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] cfg, input int n_items);
        int n_eff;
        int last;
        int ch;
        int k;
        int r;
        int base;
        wait_drained();
        reg_write(REG_CHANNELS_IN_USE, cfg);
        if (cfg == '0) begin
            n_eff = 1;
        end else if (int'(cfg) > MAX_CHANNELS) begin
            n_eff = MAX_CHANNELS;
        end else begin
            n_eff = int'(cfg);
        end
        last = n_eff - 1;
        if (n_eff <= 32) begin
            for (ch = 0; ch < n_eff; ch++) queue_delay(ch, pick_delay());
        end
        base = n_queued;
        while (n_queued - base < n_items) begin
            r = $urandom_range(0, 9);
            if (r < 7) begin
                if (n_eff <= 32) begin
                    // whole sample in channel order, a few channels dropped or doubled
                    for (ch = 0; ch < last; ch++) begin
                        k = $urandom_range(0, 9);
                        if (k != 0) queue_data(ch);
                        if (k == 1) queue_data(ch);
                    end
                end else begin
                    repeat ($urandom_range(0, 4)) queue_data($urandom_range(0, MAX_CHANNELS - 1));
                end
                queue_data(last);
            end else if (r == 7) begin
                queue_data($urandom_range(0, MAX_CHANNELS - 1));
            end else if (r == 8) begin
                queue_delay($urandom_range(0, MAX_CHANNELS - 1), $urandom_range(0, 4095));
            end else begin
                queue_data(last);
            end
        end
    endtask

    function automatic dir_row_t row_item(input t_op op, input int ch, input int a, input int b,
                                          input int c, input int d, input int dl);
        dir_row_t r;
        r = '0;
        r.item.op = op;
        r.item.ch = CHANNEL_W'(ch);
        r.item.a  = POL_W'(a);
        r.item.b  = POL_W'(b);
        r.item.c  = POL_W'(c);
        r.item.d  = POL_W'(d);
        r.item.dl = DELAY_W'(dl);
        return r;
    endfunction

    function automatic dir_row_t row_typed(input int ch, input int a, input int b, input int c,
                                           input int d, input int tot, input int dif,
                                           input int xr, input int xi);
        dir_row_t r;
        r = row_item(OP_DATA, ch, a, b, c, d, 0);
        r.item.typed = 1'b1;
        r.item.exp.sum_total      = SUM_W'(tot);
        r.item.exp.sum_difference = SUM_W'(dif);
        r.item.exp.sum_cross_real = SUM_W'(xr);
        r.item.exp.sum_cross_imag = SUM_W'(xi);
        return r;
    endfunction

    function automatic dir_row_t row_cfg(input int v);
        dir_row_t r;
        r = '0;
        r.is_cfg  = 1'b1;
        r.cfg_val = CFG_W'(v);
        return r;
    endfunction

    dir_row_t dir_tab [$];
    logic [CFG_W-1:0] cfg_list [12] = '{3, 1, 8, 2, 1024, 5, 32, 0, 4, 2047, 16, 7};

    initial begin
        int i;
        int k;
        int rand_base;
        int p;

        in_ch.valid         = 1'b0;
        in_ch.operation     = OP_DATA;
        in_ch.channel       = '0;
        in_ch.pol_a         = '0;
        in_ch.pol_b         = '0;
        in_ch.pol_c         = '0;
        in_ch.pol_d         = '0;
        in_ch.delay_samples = '0;
        out_ch.ready        = 1'b0;
        for (i = 0; i < RING_DEPTH; i++) begin
            acc_tot[i] = '0;
            acc_dif[i] = '0;
            acc_xr[i]  = '0;
            acc_xi[i]  = '0;
        end
        for (i = 0; i < MAX_CHANNELS; i++) begin
            delay_tab[i]    = '0;
            delay_loaded[i] = 1'b0;
        end
        slot_now = '0;
        chan_cfg = CFG_W'(CHAN_RESET);

        // Directed part; the first rows run with the reset channel count.
        dir_tab.push_back(row_item(OP_DELAY, 1023, 0, 0, 0, 0, 0));
        dir_tab.push_back(row_typed(1023, 255, 255, 255, 255, 510, 0, 510, 510));
        dir_tab.push_back(row_item(OP_DELAY, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row_item(OP_DATA, 0, 255, 0, 255, 255, 0));
        // delay of ring depth minus one wraps onto the slot just emitted
        dir_tab.push_back(row_item(OP_DELAY, 512, 0, 0, 0, 0, 4095));
        dir_tab.push_back(row_item(OP_DATA, 512, 'h55, 'haa, 'h55, 'haa, 0));
        dir_tab.push_back(row_item(OP_DATA, 1023, 0, 255, 0, 0, 0));
        dir_tab.push_back(row_cfg(1));
        dir_tab.push_back(row_typed(0, 255, 0, 255, 255, 255, 255, 510, 510));
        dir_tab.push_back(row_typed(0, 0, 255, 0, 0, 255, -255, 0, 0));
        // channel above the last one accumulates but never closes
        dir_tab.push_back(row_item(OP_DATA, 1023, 17, 200, 3, 250, 0));
        dir_tab.push_back(row_item(OP_DATA, 0, 0, 0, 0, 0, 0));
        dir_tab.push_back(row_item(OP_DELAY, 1, 0, 0, 0, 0, 'haaa));
        dir_tab.push_back(row_item(OP_DELAY, 2, 0, 0, 0, 0, 'h555));
        // zero channels behaves as one
        dir_tab.push_back(row_cfg(0));
        dir_tab.push_back(row_typed(0, 0, 0, 0, 0, 0, 0, 0, 0));
        // count above the table clamps to the table size
        dir_tab.push_back(row_cfg(2047));
        dir_tab.push_back(row_item(OP_DATA, 1, 255, 255, 255, 255, 0));
        dir_tab.push_back(row_item(OP_DATA, 2, 0, 0, 255, 0, 0));
        dir_tab.push_back(row_item(OP_DATA, 0, 1, 2, 3, 4, 0));
        dir_tab.push_back(row_item(OP_DATA, 1023, 128, 127, 64, 1, 0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < dir_tab.size(); i++) begin
            if (dir_tab[i].is_cfg) begin
                wait_drained();
                reg_write(REG_CHANNELS_IN_USE, dir_tab[i].cfg_val);
            end else begin
                queue_item(dir_tab[i].item);
            end
        end

        rand_base = n_queued;
        p = 0;
        while (n_queued - rand_base < 300) begin
            run_phase(cfg_list[p % 12], $urandom_range(60, 160));
            case ($urandom_range(0, 3))
                0: src_pct = 0;
                1: src_pct = 5;
                2: src_pct = 15;
                default: src_pct = 35;
            endcase
            case ($urandom_range(0, 3))
                0: snk_pct = 0;
                1: snk_pct = 5;
                2: snk_pct = 15;
                default: snk_pct = 35;
            endcase
            p++;
        end

        // Pile one channel into a single slot until the total and both cross sums
        // leave their 19-bit range.
        run_phase(CFG_W'(MAX_CHANNELS), 0);
        queue_delay(1000, 0);
        for (k = 0; k < 1040; k++) begin
            fb_item_t it;
            it = '0;
            it.op = OP_DATA;
            it.ch = CHANNEL_W'(1000);
            it.a  = '1;
            it.b  = (k % 64 == 0) ? '0 : '1;
            it.c  = '1;
            it.d  = '1;
            queue_item(it);
        end
        queue_data(MAX_CHANNELS - 1);

        // Final stretch at full rate, no idling on either side.
        wait_drained();
        src_pct = 0;
        snk_pct = 0;
        gap     = 0;
        stall   = 0;
        run_phase(CFG_W'(4), 150);

        wait_drained();
        repeat (16) @(negedge i_clk);
        if (n_err == 0) begin
            $display("incoherent_dedispersion_stokes_sum_top_tb: clean");
        end else begin
            $display("incoherent_dedispersion_stokes_sum_top_tb: errors");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("incoherent_dedispersion_stokes_sum_top_tb: errors");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/idss_pkg.sv
hw/rtl/idss_in_if.sv
hw/rtl/idss_out_if.sv
hw/rtl/idss_front.sv
hw/rtl/idss_lane.sv
hw/rtl/idss_merge.sv
hw/rtl/incoherent_dedispersion_stokes_sum_top.sv
hw/rtl/idss_checker.sv
test/incoherent_dedispersion_stokes_sum_top_tb.sv
